[rtl/core/btlv_pkg.sv]
// shared types and constants for the ber tlv header parser
// no dependencies; every other file in rtl/core except btlv_ifs imports this package
package btlv_pkg;

	// byte masks of the identifier and length octets
	localparam logic [7:0] CLASS_MASK   = 8'hC0;
	localparam logic [7:0] CONS_MASK    = 8'h20;
	localparam logic [7:0] TAG_LOW_MASK = 8'h1F;
	localparam logic [7:0] LOW7_MASK    = 8'h7F;
	localparam logic [7:0] TOP_BIT      = 8'h80;

	localparam logic [3:0] MAX_LEN_OCTETS    = 4'd8;
	localparam logic [3:0] MAX_LEN_CFG_RESET = 4'd8;

	// queue between classifier and parser
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [2:0] ROLE_TAG     = 3'd0;
	localparam logic [2:0] ROLE_LEN     = 3'd1;
	localparam logic [2:0] ROLE_CONTENT = 3'd2;
	localparam logic [2:0] ROLE_EOC     = 3'd3;
	localparam logic [2:0] ROLE_IGNORED = 3'd4;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TRUNCATED = 2'd1;
	localparam logic [1:0] ERR_LEN_LONG  = 2'd2;
	localparam logic [1:0] ERR_TAG_OVF   = 2'd3;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_TAGHI   = 3'd1,
		PH_LEN     = 3'd2,
		PH_LENLONG = 3'd3,
		PH_DEF     = 3'd4,
		PH_INDEF   = 3'd5,
		PH_ERR     = 3'd6
	} phase_t;

	// one input byte with its state-independent decode
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic [1:0] id_class;
		logic       id_cons;
		logic [4:0] tag_low;
		logic       tag_hi_form;
		logic       is_zero;
		logic       len_short;
		logic       len_indef;
		logic       long_bad;
		logic [3:0] long_cnt;
	} cls_t;

	typedef struct packed {
		logic [2:0]         byte_role;
		logic               header_done;
		logic [1:0]         tag_class;
		logic               is_constructed;
		logic [31:0]        tag_value;
		logic [63:0]        content_length;
		logic               indefinite;
		logic               element_done;
		logic signed [63:0] integer_value;
		logic [1:0]         error_code;
	} res_t;

endpackage

[rtl/core/btlv_ifs.sv]
// handshake channels of the ber tlv header parser: byte stream, results, config
// no dependencies
interface btlv_stream_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_in_buffer;

	modport source (output valid, output data_byte, output last_in_buffer, input ready);
	modport sink (input valid, input data_byte, input last_in_buffer, output ready);
endinterface

interface btlv_result_if;
	logic               valid;
	logic               ready;
	logic [2:0]         byte_role;
	logic               header_done;
	logic [1:0]         tag_class;
	logic               is_constructed;
	logic [31:0]        tag_value;
	logic [63:0]        content_length;
	logic               indefinite;
	logic               element_done;
	logic signed [63:0] integer_value;
	logic [1:0]         error_code;

	modport source (
		output valid, output byte_role, output header_done, output tag_class,
		output is_constructed, output tag_value, output content_length,
		output indefinite, output element_done, output integer_value,
		output error_code, input ready
	);
	modport sink (
		input valid, input byte_role, input header_done, input tag_class,
		input is_constructed, input tag_value, input content_length,
		input indefinite, input element_done, input integer_value,
		input error_code, output ready
	);
endinterface

interface btlv_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] max_length_bytes;

	modport source (output valid, output max_length_bytes, input ready);
	modport sink (input valid, input max_length_bytes, output ready);
endinterface

[rtl/core/btlv_front.sv]
// front end: accepts stream beats, holds the config register, decodes each byte
// depends on btlv_pkg and btlv_ifs
module btlv_front (
	input  logic            clk,
	input  logic            arst_n,
	btlv_stream_if.sink     stream,
	btlv_cfg_if.sink        cfg,
	input  logic            room,
	output logic            push,
	output btlv_pkg::cls_t  item
);
	import btlv_pkg::*;

	logic [3:0] max_len_q;
	logic [3:0] lim;
	logic [7:0] b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			max_len_q <= cfg.max_length_bytes;
		end
	end

	assign cfg.ready    = 1'b1;
	assign stream.ready = room;
	assign push         = stream.valid && room;

	assign b   = stream.data_byte;
	// counts above eight behave as eight
	assign lim = (max_len_q > MAX_LEN_OCTETS) ? MAX_LEN_OCTETS : max_len_q;

	always_comb begin
		item.data_byte   = b;
		item.last        = stream.last_in_buffer;
		item.id_class    = 2'((b & CLASS_MASK) >> 6);
		item.id_cons     = |(b & CONS_MASK);
		item.tag_low     = 5'(b & TAG_LOW_MASK);
		item.tag_hi_form = (b & TAG_LOW_MASK) == TAG_LOW_MASK;
		item.is_zero     = b == 8'h00;
		item.len_short   = (b & TOP_BIT) == 8'h00;
		item.len_indef   = b == TOP_BIT;
		item.long_bad    = (b & LOW7_MASK) > 8'(lim);
		item.long_cnt    = b[3:0];
	end

endmodule

[rtl/core/btlv_queue.sv]
// short fifo of decoded bytes between the front end and the parser
// depends on btlv_pkg
module btlv_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  btlv_pkg::cls_t wr_item,
	output logic           room,
	input  logic           pop,
	output logic           head_valid,
	output btlv_pkg::cls_t head
);
	import btlv_pkg::*;

	cls_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	// room does not look at pop, so out.ready never reaches in.ready
	assign room       = count_q != QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/btlv_back.sv]
// back end: tlv parse state machine, one decoded byte per cycle while the result is not stalled, result register
// depends on btlv_pkg
module btlv_back #(
	parameter int TAG_NUMBER_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  btlv_pkg::cls_t head,
	output logic           pop,
	output logic           res_valid,
	output btlv_pkg::res_t res,
	input  logic           res_ready
);
	import btlv_pkg::*;

	typedef struct packed {
		logic [2:0] role;
		logic       hdr;
		logic       done;
		logic [1:0] err;
		logic [1:0] shown_err;
	} step_t;

	phase_t                     phase_q, phase_d;
	logic [1:0]                 class_q, class_d;
	logic                       cons_q, cons_d;
	logic [TAG_NUMBER_BITS-1:0] tag_q, tag_d;
	logic [63:0]                len_q, len_d;
	logic [3:0]                 octs_q, octs_d;
	logic [63:0]                left_q, left_d;
	logic [63:0]                seen_q, seen_d;
	logic [63:0]                int_q, int_d;
	logic                       prev_zero_q, prev_zero_d;
	logic                       indef_q, indef_d;
	logic [1:0]                 latch_q, latch_d;
	step_t                      st;
	res_t                       res_d;
	logic [7:0]                 b;
	logic                       first;

	assign pop   = head_valid && (!res_valid || res_ready);
	assign b     = head.data_byte;
	assign first = seen_q == 64'd0;

	// next state
	always_comb begin
		phase_d     = phase_q;
		class_d     = class_q;
		cons_d      = cons_q;
		tag_d       = tag_q;
		len_d       = len_q;
		octs_d      = octs_q;
		left_d      = left_q;
		seen_d      = seen_q;
		int_d       = int_q;
		prev_zero_d = prev_zero_q;
		indef_d     = indef_q;
		latch_d     = latch_q;
		st          = '{role: ROLE_TAG, hdr: 1'b0, done: 1'b0, err: ERR_NONE,
		                shown_err: ERR_NONE};

		case (phase_q)
			PH_TAG: begin
				class_d = head.id_class;
				cons_d  = head.id_cons;
				if (head.tag_hi_form) begin
					tag_d   = '0;
					phase_d = PH_TAGHI;
				end else begin
					tag_d   = TAG_NUMBER_BITS'(head.tag_low);
					phase_d = PH_LEN;
				end
			end
			PH_TAGHI: begin
				if (tag_q[TAG_NUMBER_BITS-1 -: 7] != 7'd0) begin
					st.err = ERR_TAG_OVF;
				end else begin
					tag_d = {tag_q[TAG_NUMBER_BITS-8:0], b[6:0]};
					if (!b[7]) begin
						phase_d = PH_LEN;
					end
				end
			end
			PH_LEN: begin
				st.role = ROLE_LEN;
				indef_d = 1'b0;
				len_d   = 64'd0;
				if (head.len_short) begin
					len_d  = 64'(b);
					st.hdr = 1'b1;
				end else if (head.len_indef) begin
					indef_d = 1'b1;
					st.hdr  = 1'b1;
				end else if (head.long_bad) begin
					st.err = ERR_LEN_LONG;
				end else begin
					octs_d  = head.long_cnt;
					phase_d = PH_LENLONG;
				end
			end
			PH_LENLONG: begin
				st.role = ROLE_LEN;
				len_d   = {len_q[55:0], b};
				octs_d  = octs_q - 1'b1;
				if (octs_q == 4'd1) begin
					st.hdr = 1'b1;
				end
			end
			PH_DEF: begin
				st.role = ROLE_CONTENT;
				int_d   = first ? {{56{b[7]}}, b} : {int_q[55:0], b};
				seen_d  = seen_q + 64'd1;
				left_d  = left_q - 64'd1;
				if (left_q == 64'd1) begin
					st.done = 1'b1;
				end
			end
			PH_INDEF: begin
				st.role = ROLE_CONTENT;
				if (prev_zero_q) begin
					prev_zero_d = 1'b0;
					if (head.is_zero) begin
						st.role = ROLE_EOC;
						st.done = 1'b1;
					end else begin
						// held zero goes in ahead of this byte
						int_d  = first ? 64'(b) : {int_q[47:0], 8'h00, b};
						seen_d = seen_q + 64'd2;
					end
				end else if (head.is_zero) begin
					prev_zero_d = 1'b1;
				end else begin
					int_d  = first ? {{56{b[7]}}, b} : {int_q[55:0], b};
					seen_d = seen_q + 64'd1;
				end
			end
			default: begin
				st.role = ROLE_IGNORED;
			end
		endcase

		if (st.hdr) begin
			seen_d      = 64'd0;
			int_d       = 64'd0;
			prev_zero_d = 1'b0;
			if (indef_d) begin
				phase_d = PH_INDEF;
			end else if (len_d == 64'd0) begin
				st.done = 1'b1;
			end else begin
				left_d  = len_d;
				phase_d = PH_DEF;
			end
		end
		if (st.done) begin
			phase_d = PH_TAG;
		end
		if (st.err != ERR_NONE) begin
			latch_d = st.err;
			phase_d = PH_ERR;
		end
		if (head.last && phase_d != PH_TAG && phase_d != PH_ERR) begin
			latch_d = ERR_TRUNCATED;
		end
		st.shown_err = latch_d;
		// end of buffer re-arms the parser
		if (head.last) begin
			phase_d     = PH_TAG;
			latch_d     = ERR_NONE;
			prev_zero_d = 1'b0;
		end
	end

	// result fields
	always_comb begin
		res_d                = '0;
		res_d.byte_role      = st.role;
		res_d.header_done    = st.hdr;
		res_d.element_done   = st.done;
		res_d.error_code     = st.shown_err;
		if (st.hdr || st.done) begin
			res_d.tag_class      = class_d;
			res_d.is_constructed = cons_d;
			res_d.tag_value      = 32'(tag_d);
			res_d.indefinite     = indef_d;
		end
		if (st.done) begin
			res_d.content_length = seen_d;
			res_d.integer_value  = int_d;
		end else if (st.hdr && !indef_d) begin
			res_d.content_length = len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			class_q     <= '0;
			cons_q      <= 1'b0;
			tag_q       <= '0;
			len_q       <= '0;
			octs_q      <= '0;
			left_q      <= '0;
			seen_q      <= '0;
			int_q       <= '0;
			prev_zero_q <= 1'b0;
			indef_q     <= 1'b0;
			latch_q     <= ERR_NONE;
			res_valid   <= 1'b0;
		end else begin
			if (pop) begin
				phase_q     <= phase_d;
				class_q     <= class_d;
				cons_q      <= cons_d;
				tag_q       <= tag_d;
				len_q       <= len_d;
				octs_q      <= octs_d;
				left_q      <= left_d;
				seen_q      <= seen_d;
				int_q       <= int_d;
				prev_zero_q <= prev_zero_d;
				indef_q     <= indef_d;
				latch_q     <= latch_d;
				res_valid   <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res <= res_d;
		end
	end

endmodule

[rtl/core/ber_tlv_header_parser_top.sv]
// top level of the ber tlv header parser: front end, byte queue, parser back end
// depends on btlv_pkg, btlv_ifs, btlv_front, btlv_queue and btlv_back
//
// Walks a flat run of BER TLV elements one byte per beat and returns one result
// beat per input beat, in order. Sustained rate is one byte per clock while the
// output is not stalled; a byte's result goes through the queue, then the output
// register. The rate is set by the parser state update, which consumes one decoded
// byte per cycle while the output register is free, from a two-entry queue fed by
// the byte decoder; the queue and the output register let input and output stall
// independently. The user must write the config register (long-form length octet
// limit, reset 8) only while no byte is in flight; the block does not enforce it.
module ber_tlv_header_parser_top #(
	parameter int TAG_NUMBER_BITS = 32
) (
	input logic            clk,
	input logic            arst_n,
	btlv_stream_if.sink    stream,
	btlv_result_if.source  result,
	btlv_cfg_if.sink       cfg
);
	import btlv_pkg::*;

	logic room;
	logic push;
	cls_t item;
	logic pop;
	logic head_valid;
	cls_t head;
	res_t res;

	btlv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.cfg    (cfg),
		.room   (room),
		.push   (push),
		.item   (item)
	);

	btlv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_item    (item),
		.room       (room),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	btlv_back #(
		.TAG_NUMBER_BITS (TAG_NUMBER_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (result.valid),
		.res        (res),
		.res_ready  (result.ready)
	);

	assign result.byte_role      = res.byte_role;
	assign result.header_done    = res.header_done;
	assign result.tag_class      = res.tag_class;
	assign result.is_constructed = res.is_constructed;
	assign result.tag_value      = res.tag_value;
	assign result.content_length = res.content_length;
	assign result.indefinite     = res.indefinite;
	assign result.element_done   = res.element_done;
	assign result.integer_value  = res.integer_value;
	assign result.error_code     = res.error_code;

endmodule

[rtl/core/btlv_checker.sv]
// port-level checks on the result channel of the ber tlv header parser
// depends on btlv_pkg; bound to ber_tlv_header_parser_top
module btlv_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input logic [2:0]         byte_role,
	input logic               header_done,
	input logic               element_done,
	input logic               indefinite,
	input logic [63:0]        content_length,
	input logic signed [63:0] integer_value,
	input logic [1:0]         error_code
);
	import btlv_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(byte_role)
			&& $stable(content_length) && $stable(integer_value) && $stable(error_code))
		else $error("result beat changed while stalled");

	// bytes ignored after an error carry the latched code and nothing else
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_role == ROLE_IGNORED |->
			error_code != ERR_NONE && !header_done && !element_done
			&& content_length == 64'd0 && integer_value == 64'sd0)
		else $error("ignored byte with fields or without error");

	// end-of-contents marker only closes an indefinite element
	a_eoc: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && byte_role == ROLE_EOC |-> element_done && indefinite)
		else $error("end-of-contents marker outside indefinite element");

	// indefinite header reports no length
	a_indef_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && header_done && indefinite |->
			content_length == 64'd0 && !element_done && byte_role == ROLE_LEN)
		else $error("indefinite header with a length");

endmodule

bind ber_tlv_header_parser_top btlv_checker u_btlv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (result.valid),
	.res_ready      (result.ready),
	.byte_role      (result.byte_role),
	.header_done    (result.header_done),
	.element_done   (result.element_done),
	.indefinite     (result.indefinite),
	.content_length (result.content_length),
	.integer_value  (result.integer_value),
	.error_code     (result.error_code)
);

[dv/ber_tlv_header_parser_checker.sv]
// checker for the ber tlv header parser: replays every accepted byte through its own
// copy of the parse state and compares each result beat with the oldest decoded byte
// depends on btlv_pkg and btlv_ifs
module ber_tlv_header_parser_checker #(
	parameter int TAG_NUMBER_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	btlv_stream_if stream,
	btlv_result_if result,
	btlv_cfg_if    cfg,
	output int     fail_count,
	output int     beats_in_flight
);
	import btlv_pkg::*;

	phase_t      ph;
	logic [3:0]  len_limit;
	logic [1:0]  id_class;
	logic        id_cons;
	logic [63:0] tag_num;
	logic [63:0] len_acc;
	logic [3:0]  octets_left;
	logic [63:0] content_left;
	logic [63:0] content_count;
	logic [63:0] int_acc;
	logic        zero_held;
	logic        indef_form;
	logic [1:0]  err_latch;
	res_t        decoded_q[$];
	int          beat_no;

	// big-endian gather, sign taken from the first content byte
	function automatic void gather_content(input logic [7:0] v);
		if (content_count == 0)
			int_acc = {{56{v[7]}}, v};
		else
			int_acc = {int_acc[55:0], v};
		content_count = content_count + 64'd1;
	endfunction

	function automatic res_t decode_byte(input logic [7:0] b, input logic eob);
		res_t       r;
		logic       hdr;
		logic       done;
		logic [1:0] err;
		int         n_oct;
		int         lim;
		r = '0;
		hdr = 1'b0;
		done = 1'b0;
		err = ERR_NONE;
		r.byte_role = ROLE_TAG;
		case (ph)
		PH_TAG: begin
			id_class = b[7:6];
			id_cons = b[5];
			tag_num = {59'd0, b[4:0]};
			if (b[4:0] == TAG_LOW_MASK[4:0]) begin
				tag_num = '0;
				ph = PH_TAGHI;
			end else
				ph = PH_LEN;
		end
		PH_TAGHI: begin
			if ((tag_num >> (TAG_NUMBER_BITS - 7)) != 0)
				err = ERR_TAG_OVF;
			else begin
				tag_num = (tag_num << 7) | {57'd0, b[6:0]};
				if (!b[7])
					ph = PH_LEN;
			end
		end
		PH_LEN: begin
			r.byte_role = ROLE_LEN;
			indef_form = 1'b0;
			len_acc = '0;
			if (!b[7]) begin
				len_acc = {56'd0, b};
				hdr = 1'b1;
			end else if (b == TOP_BIT) begin
				indef_form = 1'b1;
				hdr = 1'b1;
			end else begin
				n_oct = int'(b[6:0]);
				lim = int'((len_limit > MAX_LEN_OCTETS) ? MAX_LEN_OCTETS : len_limit);
				if (n_oct > lim)
					err = ERR_LEN_LONG;
				else begin
					octets_left = n_oct[3:0];
					ph = PH_LENLONG;
				end
			end
		end
		PH_LENLONG: begin
			r.byte_role = ROLE_LEN;
			len_acc = {len_acc[55:0], b};
			octets_left = octets_left - 4'd1;
			if (octets_left == 0)
				hdr = 1'b1;
		end
		PH_DEF: begin
			r.byte_role = ROLE_CONTENT;
			gather_content(b);
			content_left = content_left - 64'd1;
			if (content_left == 0)
				done = 1'b1;
		end
		PH_INDEF: begin
			r.byte_role = ROLE_CONTENT;
			// a lone zero waits for the next byte to tell marker from content
			if (zero_held) begin
				zero_held = 1'b0;
				if (b == 8'h00) begin
					r.byte_role = ROLE_EOC;
					done = 1'b1;
				end else begin
					gather_content(8'h00);
					gather_content(b);
				end
			end else if (b == 8'h00)
				zero_held = 1'b1;
			else
				gather_content(b);
		end
		default: r.byte_role = ROLE_IGNORED;
		endcase

		if (hdr) begin
			content_count = '0;
			int_acc = '0;
			zero_held = 1'b0;
			if (indef_form)
				ph = PH_INDEF;
			else if (len_acc == 0)
				done = 1'b1;
			else begin
				content_left = len_acc;
				ph = PH_DEF;
			end
		end
		if (done)
			ph = PH_TAG;
		if (err != ERR_NONE) begin
			err_latch = err;
			ph = PH_ERR;
		end
		if (eob && ph != PH_TAG && ph != PH_ERR)
			err_latch = ERR_TRUNCATED;

		r.header_done = hdr;
		if (hdr || done) begin
			r.tag_class = id_class;
			r.is_constructed = id_cons;
			r.tag_value = tag_num[31:0];
			r.indefinite = indef_form;
		end
		if (hdr)
			r.content_length = indef_form ? 64'd0 : len_acc;
		if (done) begin
			r.content_length = content_count;
			r.integer_value = int_acc;
		end
		r.element_done = done;
		r.error_code = err_latch;

		// end of buffer re-arms the parser
		if (eob) begin
			ph = PH_TAG;
			err_latch = ERR_NONE;
			zero_held = 1'b0;
		end
		return r;
	endfunction

	function automatic void show(input string label, input res_t r);
		$display("%s role %0d hdr %0b cls %0d cons %0b tag %0h len %0h indef %0b done %0b",
			label, r.byte_role, r.header_done, r.tag_class, r.is_constructed, r.tag_value,
			r.content_length, r.indefinite, r.element_done);
		$display("%s   int %0h err %0d", label, r.integer_value, r.error_code);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		res_t got;
		if (!arst_n) begin
			ph = PH_TAG;
			len_limit = MAX_LEN_CFG_RESET;
			id_class = '0;
			id_cons = 1'b0;
			tag_num = '0;
			len_acc = '0;
			octets_left = '0;
			content_left = '0;
			content_count = '0;
			int_acc = '0;
			zero_held = 1'b0;
			indef_form = 1'b0;
			err_latch = ERR_NONE;
			decoded_q.delete();
			beat_no = 0;
			fail_count = 0;
			beats_in_flight = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				len_limit = cfg.max_length_bytes;
			if (stream.valid && stream.ready)
				decoded_q.push_back(decode_byte(stream.data_byte, stream.last_in_buffer));
			if (result.valid && result.ready) begin
				got.byte_role = result.byte_role;
				got.header_done = result.header_done;
				got.tag_class = result.tag_class;
				got.is_constructed = result.is_constructed;
				got.tag_value = result.tag_value;
				got.content_length = result.content_length;
				got.indefinite = result.indefinite;
				got.element_done = result.element_done;
				got.integer_value = result.integer_value;
				got.error_code = result.error_code;
				if (decoded_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("result beat %0d arrived with no byte outstanding", beat_no);
						show("  got ", got);
					end
				end else begin
					want = decoded_q.pop_front();
					if (got.byte_role !== want.byte_role
						|| got.header_done !== want.header_done
						|| got.tag_class !== want.tag_class
						|| got.is_constructed !== want.is_constructed
						|| got.tag_value !== want.tag_value
						|| got.content_length !== want.content_length
						|| got.indefinite !== want.indefinite
						|| got.element_done !== want.element_done
						|| got.integer_value !== want.integer_value
						|| got.error_code !== want.error_code) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result beat %0d mismatch", beat_no);
							show("  want", want);
							show("  got ", got);
						end
					end
				end
				beat_no++;
			end
			beats_in_flight = decoded_q.size();
		end
	end

endmodule

[dv/ber_tlv_header_parser_top_tb.sv]
// testbench top for ber_tlv_header_parser_top: drives byte buffers and limit writes,
// paces the result channel and reports the verdict from ber_tlv_header_parser_checker
// depends on btlv_pkg, btlv_ifs, the parser rtl and the checker
module ber_tlv_header_parser_top_tb;
	import btlv_pkg::*;

	localparam int BYTE_TARGET = 1650;
	localparam int PHASES      = 6;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        idle_on;
	logic [3:0]  cur_limit;
	logic [7:0]  frame_q[$];
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          limits_set = 0;
	int          cycles = 0;
	int          fail_count;
	int          beats_in_flight;

	btlv_stream_if stream_ch ();
	btlv_result_if result_ch ();
	btlv_cfg_if    cfg_ch ();

	ber_tlv_header_parser_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	ber_tlv_header_parser_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.stream          (stream_ch),
		.result          (result_ch),
		.cfg             (cfg_ch),
		.fail_count      (fail_count),
		.beats_in_flight (beats_in_flight)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("ber_tlv_header_parser_top_tb: errors");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	initial begin : result_pacing
		int n;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 9) == 0) begin
				n = $urandom_range(1, 16);
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		int n;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 16);
			stream_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		stream_ch.valid          <= 1'b1;
		stream_ch.data_byte      <= b;
		stream_ch.last_in_buffer <= eob;
		do @(posedge clk); while (!stream_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		int i;
		for (i = 0; i < frame_q.size(); i++)
			send_byte(frame_q[i], i == frame_q.size() - 1);
		frame_q.delete();
		frames_sent++;
	endtask

	// wait until every byte has its result beat and the pipe has gone quiet
	task automatic drain();
		stream_ch.valid <= 1'b0;
		do @(posedge clk); while (beats_in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [3:0] v);
		drain();
		cfg_ch.valid            <= 1'b1;
		cfg_ch.max_length_bytes <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_limit = v;
		limits_set++;
	endtask

	function automatic logic [7:0] content_byte();
		logic [7:0] v;
		case ($urandom_range(0, 7))
		0, 1: v = 8'h00;
		2: v = 8'hFF;
		3: v = TOP_BIT;
		default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	function automatic int eff_limit();
		return int'((cur_limit > MAX_LEN_OCTETS) ? MAX_LEN_OCTETS : cur_limit);
	endfunction

	// cont_bytes of zero gives the low tag form
	task automatic add_identifier(input int cont_bytes);
		logic [2:0] id_hi;
		logic [4:0] low_tag;
		logic [6:0] seven;
		logic       more;
		int         i;
		id_hi = 3'($urandom_range(0, 7));
		if (cont_bytes == 0) begin
			low_tag = 5'($urandom_range(0, 30));
			frame_q.push_back({id_hi, low_tag});
		end else begin
			frame_q.push_back({id_hi, TAG_LOW_MASK[4:0]});
			for (i = 0; i < cont_bytes; i++) begin
				seven = 7'($urandom_range(0, 127));
				more = (i < cont_bytes - 1);
				frame_q.push_back({more, seven});
			end
		end
	endtask

	task automatic add_element();
		int         clen;
		int         sel;
		int         n;
		int         i;
		logic [7:0] nb;
		logic [7:0] prev;
		logic [7:0] v;
		add_identifier(($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
		sel = $urandom_range(0, 9);
		clen = (sel < 6) ? $urandom_range(0, 4) : (sel < 9) ? $urandom_range(5, 10)
			: $urandom_range(11, 16);
		sel = $urandom_range(0, 9);
		if (sel >= 7 && eff_limit() > 0) begin
			n = $urandom_range(1, eff_limit());
			nb = 8'(n);
			frame_q.push_back(TOP_BIT | nb);
			repeat (n - 1) frame_q.push_back(8'h00);
			frame_q.push_back(clen[7:0]);
			repeat (clen) frame_q.push_back(content_byte());
		end else if (sel >= 5) begin
			// indefinite: no zero pair inside and no zero just before the marker
			frame_q.push_back(TOP_BIT);
			prev = 8'h01;
			for (i = 0; i < clen; i++) begin
				v = content_byte();
				if (v == 8'h00 && (prev == 8'h00 || i == clen - 1))
					v = 8'h01;
				frame_q.push_back(v);
				prev = v;
			end
			frame_q.push_back(8'h00);
			frame_q.push_back(8'h00);
		end else begin
			frame_q.push_back(clen[7:0]);
			repeat (clen) frame_q.push_back(content_byte());
		end
	endtask

	task automatic add_fault();
		int         n;
		logic [7:0] nb;
		logic [6:0] seven;
		case ($urandom_range(0, 5))
		0: begin
			// buffer ends inside an element
			add_element();
			if (frame_q.size() > 1) begin
				n = $urandom_range(1, frame_q.size() - 1);
				while (frame_q.size() > n)
					void'(frame_q.pop_back());
			end
		end
		1: begin
			// wide long-form length whose content never arrives
			add_identifier(0);
			n = $urandom_range(1, 8);
			nb = 8'(n);
			frame_q.push_back(TOP_BIT | nb);
			repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
			repeat ($urandom_range(0, 3)) frame_q.push_back(content_byte());
		end
		2: begin
			add_identifier(0);
			n = $urandom_range(eff_limit() + 1, 127);
			nb = 8'(n);
			frame_q.push_back(TOP_BIT | nb);
			repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
		end
		3: begin
			add_identifier(0);
			frame_q.push_back(8'hFF);
			frame_q.push_back(8'($urandom_range(0, 255)));
		end
		4: begin
			// leading continuation byte full of ones so the tag number runs out of bits
			add_identifier(0);
			frame_q[frame_q.size() - 1][4:0] = TAG_LOW_MASK[4:0];
			frame_q.push_back(8'hFF);
			repeat ($urandom_range(3, 5)) begin
				seven = 7'($urandom_range(0, 127));
				frame_q.push_back({1'b1, seven});
			end
			frame_q.push_back(8'($urandom_range(0, 255)));
		end
		default: repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic build_buffer();
		repeat ($urandom_range(1, 4)) add_element();
		if ($urandom_range(0, 4) == 0) begin
			add_fault();
			repeat ($urandom_range(0, 2)) add_element();
		end
	endtask

	initial begin : stimulus
		int         p;
		int         rnd_base;
		logic [3:0] limit_plan[PHASES];
		stream_ch.valid          = 1'b0;
		stream_ch.data_byte      = 8'h00;
		stream_ch.last_in_buffer = 1'b0;
		cfg_ch.valid             = 1'b0;
		cfg_ch.max_length_bytes  = 4'd0;
		arst_n                   = 1'b0;
		idle_on                  = 1'b1;
		cur_limit                = MAX_LEN_CFG_RESET;
		limit_plan = '{4'd0, 4'd15, 4'd1, 4'd3, 4'd8, 4'd5};
		limit_plan[3] = 4'($urandom_range(2, 7));
		limit_plan[5] = 4'($urandom_range(0, 15));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty content, high tag with -1, indefinite with a held zero, long form
		frame_q = '{8'h02, 8'h00, 8'hDF, 8'h7F, 8'h01, 8'hFF, 8'h30, 8'h80, 8'h00, 8'h05,
			8'h00, 8'h00, 8'h04, 8'h81, 8'h02, 8'h80, 8'h00};
		send_frame();
		// reserved length byte
		frame_q = '{8'h05, 8'hFF};
		send_frame();
		// tag number overflow
		frame_q = '{8'h3F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01};
		send_frame();
		// truncated content
		frame_q = '{8'h02, 8'h02, 8'h01};
		send_frame();

		rnd_base = bytes_sent;
		for (p = 0; p < PHASES; p++) begin
			set_limit(limit_plan[p]);
			idle_on = (p < PHASES - 1);
			while (bytes_sent < rnd_base + (p + 1) * BYTE_TARGET / PHASES) begin
				build_buffer();
				send_frame();
			end
		end

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d bytes in %0d buffers over %0d length-octet limit settings",
			bytes_sent, frames_sent, limits_set);
		$display("including limits 0 and 15, truncation, reserved length and tag overflow");
		if (fail_count == 0 && beats_in_flight == 0)
			$display("ber_tlv_header_parser_top_tb: clean");
		else
			$display("ber_tlv_header_parser_top_tb: errors");
		$finish;
	end

endmodule
